// File: rtl/lwps_pkg.sv
`timescale 1ns / 1ps
// lwps_pkg: shared types and constants for the lexicon word polarity scorer
// used by lwps_match and lexicon_word_polarity_scorer_unit, no dependencies
package lwps_pkg;

  localparam int DEF_LEX_DEPTH = 64;
  localparam int DEF_MAX_WORD  = 20;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CASE_BIT   = 8'h20;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7a;

  typedef enum logic [1:0] {
    MODE_LEX_CHAR = 2'd0,
    MODE_LEX_POL  = 2'd1,
    MODE_BYTE     = 2'd2,
    MODE_END      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              en;
    logic              is_pol;
    logic [5:0]        entry;
    logic [4:0]        pos;
    logic [7:0]        char_code;
    logic signed [7:0] polarity;
  } lex_wr_t;

  typedef struct packed {
    logic       en;
    logic [5:0] addr;
    logic [7:0] data;
  } wb_wr_t;

  typedef struct packed {
    logic       start;
    logic [6:0] len;
    logic [6:0] n;
  } srch_req_t;

  typedef struct packed {
    logic              done;
    logic signed [7:0] polarity;
  } srch_rsp_t;

endpackage

// File: rtl/lexicon_word_polarity_scorer_unit.sv
`timescale 1ns / 1ps
// lexicon_word_polarity_scorer_unit: top level, word assembly, totals and result register
// depends on lwps_pkg and lwps_match
//
// Lexicon writes, letters and dropped bytes need no search and cause no stall. A space or an
// end-of-comment transaction scores the buffered word against lexicon entries
// 0 .. min(lexicon_size, LEX_DEPTH)-1 through the single read port of the lexicon
// character memory, one character per cycle: an entry that mismatches drops the
// read in flight and the search restarts at the next entry, and the search stops at the
// first hit. A word end then posts its result from the emit state; no search runs
// for empty or too-long words or an empty lexicon.
// Input stalls only while a word end is being scored or its result is being posted
// to the output register. Lexicon contents are undefined until written.
module lexicon_word_polarity_scorer_unit import lwps_pkg::*; #(
  parameter int LEX_DEPTH = DEF_LEX_DEPTH,
  parameter int MAX_WORD  = DEF_MAX_WORD
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [5:0]         entry_index,
  input  logic [4:0]         char_position,
  input  logic [7:0]         char_code,
  input  logic signed [7:0]  polarity_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  word_polarity,
  output logic signed [15:0] total_polarity,
  output logic [7:0]         word_count,
  output logic               comment_end
);

  localparam int LW = $clog2(MAX_WORD + 1);

  state_t state;
  state_t state_next;

  logic [6:0]         lexicon_size;
  logic [LW-1:0]      word_length;
  logic               word_too_long;
  logic signed [15:0] running_total;
  logic [7:0]         running_count;
  logic               is_end;
  logic               do_finish;
  logic signed [7:0]  word_pol;

  mode_t              in_mode;
  logic               accept;
  logic               is_upper;
  logic               is_letter;
  logic [7:0]         letter_lc;
  logic               word_end;
  logic               pending;
  logic               can_search;
  logic               room;
  logic [6:0]         n_eff;
  logic               out_free;
  logic signed [16:0] sum;
  logic signed [15:0] sum_sat;
  logic [7:0]         count_inc;

  lex_wr_t   lex_wr;
  wb_wr_t    wb_wr;
  srch_req_t req;
  srch_rsp_t rsp;

  assign in_mode   = mode_t'(mode);
  assign in_stall  = state != ST_IDLE;
  assign accept    = in_valid && !in_stall;
  assign is_upper  = char_code >= CHAR_UP_A && char_code <= CHAR_UP_Z;
  assign is_letter = is_upper || (char_code >= CHAR_LO_A && char_code <= CHAR_LO_Z);
  assign letter_lc = is_upper ? (char_code | CASE_BIT) : char_code;
  assign word_end  = accept && ((in_mode == MODE_BYTE && char_code == CHAR_SPACE) ||
                                in_mode == MODE_END);
  assign pending   = (in_mode == MODE_BYTE) || word_length != '0 || word_too_long;
  assign room      = word_length < LW'(MAX_WORD);
  assign n_eff     = (32'(lexicon_size) > LEX_DEPTH) ? 7'(LEX_DEPTH) : lexicon_size;
  assign can_search = pending && !word_too_long && word_length != '0 && n_eff != 7'd0;
  assign out_free  = !out_valid || !out_stall;

  assign sum       = {running_total[15], running_total} + {{9{word_pol[7]}}, word_pol};
  assign sum_sat   = (sum[16] != sum[15]) ? (sum[16] ? 16'sh8000 : 16'sh7fff) : sum[15:0];
  assign count_inc = (running_count == 8'hff) ? running_count : running_count + 8'd1;

  assign lex_wr.en        = accept && (in_mode == MODE_LEX_CHAR || in_mode == MODE_LEX_POL);
  assign lex_wr.is_pol    = in_mode == MODE_LEX_POL;
  assign lex_wr.entry     = entry_index;
  assign lex_wr.pos       = char_position;
  assign lex_wr.char_code = char_code;
  assign lex_wr.polarity  = polarity_value;

  assign wb_wr.en   = accept && in_mode == MODE_BYTE && is_letter && room;
  assign wb_wr.addr = 6'(word_length);
  assign wb_wr.data = letter_lc;

  assign req.len = 7'(word_length);
  assign req.n   = n_eff;

  lwps_match #(
    .LEX_DEPTH (LEX_DEPTH),
    .MAX_WORD  (MAX_WORD)
  ) u_match (
    .clk    (clk),
    .rst    (rst),
    .lex_wr (lex_wr),
    .wb_wr  (wb_wr),
    .req    (req),
    .rsp    (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (word_end) begin
          if (can_search) begin
            req.start  = 1'b1;
            state_next = ST_SEARCH;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_SEARCH: begin
        if (rsp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lexicon_size  <= '0;
      word_length   <= '0;
      word_too_long <= 1'b0;
      running_total <= '0;
      running_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lexicon_size <= cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && in_mode == MODE_BYTE && is_letter) begin
            if (room) begin
              word_length <= word_length + 1'b1;
            end else begin
              word_too_long <= 1'b1;
            end
          end
          if (word_end) begin
            is_end    <= in_mode == MODE_END;
            do_finish <= pending;
            word_pol  <= 8'sd0;
          end
        end
        ST_SEARCH: begin
          if (rsp.done) begin
            word_pol <= rsp.polarity;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            word_polarity  <= word_pol;
            total_polarity <= do_finish ? sum_sat : running_total;
            word_count     <= do_finish ? count_inc : running_count;
            comment_end    <= is_end;
            if (is_end) begin
              running_total <= '0;
              running_count <= '0;
            end else if (do_finish) begin
              running_total <= sum_sat;
              running_count <= count_inc;
            end
            word_length   <= '0;
            word_too_long <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/lwps_match.sv
`timescale 1ns / 1ps
// lwps_match: lexicon and word buffer memories plus the pipelined match sequencer
// depends on lwps_pkg
module lwps_match import lwps_pkg::*; #(
  parameter int LEX_DEPTH = DEF_LEX_DEPTH,
  parameter int MAX_WORD  = DEF_MAX_WORD
) (
  input  logic      clk,
  input  logic      rst,
  input  lex_wr_t   lex_wr,
  input  wb_wr_t    wb_wr,
  input  srch_req_t req,
  output srch_rsp_t rsp
);

  localparam int IW         = (LEX_DEPTH > 1) ? $clog2(LEX_DEPTH) : 1;
  localparam int PW         = $clog2(MAX_WORD);
  localparam int LW         = $clog2(MAX_WORD + 1);
  localparam int CHAR_DEPTH = 2 ** (IW + PW);
  localparam int POL_DEPTH  = 2 ** IW;

  logic [7:0] char_mem [CHAR_DEPTH];
  logic [7:0] pol_mem  [POL_DEPTH];
  logic [7:0] wb_mem   [MAX_WORD];

  logic [7:0] char_q;
  logic [7:0] pol_q;
  logic [7:0] wb_q;

  logic          busy;
  logic          iss_on;
  logic [6:0]    iss_entry;
  logic [PW-1:0] iss_pos;
  logic          cmp_valid;
  logic [6:0]    cmp_entry;
  logic [PW-1:0] cmp_pos;
  logic [LW-1:0] len_q;
  logic [PW-1:0] last_pos;
  logic [6:0]    n_q;

  logic          entry_ok;
  logic          pos_ok;
  logic [LW-1:0] req_len;
  logic [PW-1:0] req_last;
  logic [7:0]    expected;
  logic          match;
  logic          found;
  logic          miss;
  logic [6:0]    iss_entry_nx;
  logic [6:0]    cmp_entry_nx;

  assign entry_ok = 32'(lex_wr.entry) < LEX_DEPTH;
  assign pos_ok   = 32'(lex_wr.pos) < MAX_WORD;

  // lexicon and word buffer write ports
  always_ff @(posedge clk) begin
    if (lex_wr.en && !lex_wr.is_pol && entry_ok && pos_ok) begin
      char_mem[{IW'(lex_wr.entry), PW'(lex_wr.pos)}] <= lex_wr.char_code;
    end
    if (lex_wr.en && lex_wr.is_pol && entry_ok) begin
      pol_mem[IW'(lex_wr.entry)] <= lex_wr.polarity;
    end
    if (wb_wr.en) begin
      wb_mem[PW'(wb_wr.addr)] <= wb_wr.data;
    end
  end

  // read ports follow the issue address
  always_ff @(posedge clk) begin
    char_q <= char_mem[{IW'(iss_entry), iss_pos}];
    pol_q  <= pol_mem[IW'(iss_entry)];
    wb_q   <= wb_mem[iss_pos];
  end

  assign req_len      = LW'(req.len);
  assign req_last     = (req_len == LW'(MAX_WORD)) ? PW'(req_len - 1'b1) : PW'(req_len);
  assign expected     = (LW'(cmp_pos) < len_q) ? wb_q : CHAR_NUL;
  assign match        = char_q == expected;
  assign found        = busy && cmp_valid && match && (cmp_pos == last_pos);
  assign miss         = busy && !cmp_valid && !iss_on;
  assign iss_entry_nx = iss_entry + 7'd1;
  assign cmp_entry_nx = cmp_entry + 7'd1;

  assign rsp.done     = found || miss;
  assign rsp.polarity = found ? pol_q : 8'sd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      iss_on    <= 1'b0;
      cmp_valid <= 1'b0;
    end else if (req.start) begin
      busy      <= 1'b1;
      iss_on    <= 1'b1;
      iss_entry <= '0;
      iss_pos   <= '0;
      cmp_valid <= 1'b0;
      len_q     <= req_len;
      last_pos  <= req_last;
      n_q       <= req.n;
    end else if (busy) begin
      if (rsp.done) begin
        busy      <= 1'b0;
        iss_on    <= 1'b0;
        cmp_valid <= 1'b0;
      end else if (cmp_valid && !match) begin
        // mismatch: drop the read in flight and restart on the next entry
        iss_entry <= cmp_entry_nx;
        iss_pos   <= '0;
        iss_on    <= cmp_entry_nx < n_q;
        cmp_valid <= 1'b0;
      end else begin
        cmp_valid <= iss_on;
        cmp_entry <= iss_entry;
        cmp_pos   <= iss_pos;
        if (iss_on) begin
          if (iss_pos == last_pos) begin
            iss_entry <= iss_entry_nx;
            iss_pos   <= '0;
            iss_on    <= iss_entry_nx < n_q;
          end else begin
            iss_pos <= iss_pos + 1'b1;
          end
        end
      end
    end
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("search started while busy");

  a_issue_range: assert property (@(posedge clk) disable iff (rst)
    busy && iss_on |-> iss_entry < n_q)
    else $error("issue entry beyond searched range");

  a_cmp_pos: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> cmp_pos <= last_pos)
    else $error("compare position past last character");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !busy && !cmp_valid)
    else $error("search still active after done");

  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> n_q != 7'd0 && len_q != '0)
    else $error("search running on empty word or lexicon");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for lexicon_word_polarity_scorer_unit
// needs lwps_pkg and the unit itself, scoring predicted by a small tracker class

typedef struct packed {
  logic signed [7:0]  pol;
  logic signed [15:0] total;
  logic [7:0]         count;
  logic               last;
} score_t;

class score_tracker;
  logic [7:0]        lex_chars [lwps_pkg::DEF_LEX_DEPTH][lwps_pkg::DEF_MAX_WORD];
  logic signed [7:0] lex_pol [lwps_pkg::DEF_LEX_DEPTH];
  logic [7:0]        word_buf [lwps_pkg::DEF_MAX_WORD];
  int                word_len;
  bit                too_long;
  int                total;
  int                count;
  int                lex_size;
  score_t            pending_scores [$];
  int                errors;
  int                n_items;
  int                n_scores;

  function new();
    word_len = 0;
    too_long = 0;
    total    = 0;
    count    = 0;
    lex_size = 0;
    errors   = 0;
    n_items  = 0;
    n_scores = 0;
  endfunction

  function void set_size(logic [6:0] v);
    lex_size = v;
  endfunction

  function int waiting();
    return pending_scores.size();
  endfunction

  function logic signed [7:0] find_polarity();
    int n;
    bit same;
    n = (lex_size > lwps_pkg::DEF_LEX_DEPTH) ? lwps_pkg::DEF_LEX_DEPTH : lex_size;
    if (too_long || word_len == 0) return 8'sd0;
    for (int i = 0; i < n; i++) begin
      same = 1;
      for (int k = 0; k < word_len; k++) begin
        if (lex_chars[i][k] != word_buf[k]) begin
          same = 0;
          break;
        end
      end
      if (same && word_len < lwps_pkg::DEF_MAX_WORD &&
          lex_chars[i][word_len] != lwps_pkg::CHAR_NUL)
        same = 0;
      if (same) return lex_pol[i];
    end
    return 8'sd0;
  endfunction

  function logic signed [7:0] close_word();
    logic signed [7:0] p;
    int t;
    p = find_polarity();
    t = total + p;
    if (t > 32767) t = 32767;
    else if (t < -32768) t = -32768;
    total = t;
    if (count < 255) count++;
    word_len = 0;
    too_long = 0;
    return p;
  endfunction

  function void push_score(logic signed [7:0] p, logic last);
    score_t s;
    s.pol   = p;
    s.total = total[15:0];
    s.count = count[7:0];
    s.last  = last;
    pending_scores.push_back(s);
  endfunction

  // predict the effect of one accepted input transaction
  function void score_transaction(lwps_pkg::mode_t m, logic [5:0] e, logic [4:0] pos,
                                  logic [7:0] ch, logic signed [7:0] pol);
    bit is_up;
    bit is_lo;
    logic signed [7:0] p;
    n_items++;
    is_up = ch >= lwps_pkg::CHAR_UP_A && ch <= lwps_pkg::CHAR_UP_Z;
    is_lo = ch >= lwps_pkg::CHAR_LO_A && ch <= lwps_pkg::CHAR_LO_Z;
    case (m)
      lwps_pkg::MODE_LEX_CHAR: begin
        if (pos < lwps_pkg::DEF_MAX_WORD) lex_chars[e][pos] = ch;
      end
      lwps_pkg::MODE_LEX_POL: begin
        lex_pol[e] = pol;
      end
      lwps_pkg::MODE_BYTE: begin
        if (is_up || is_lo) begin
          if (word_len < lwps_pkg::DEF_MAX_WORD) begin
            word_buf[word_len] = is_up ? (ch | lwps_pkg::CASE_BIT) : ch;
            word_len++;
          end else begin
            too_long = 1;
          end
        end else if (ch == lwps_pkg::CHAR_SPACE) begin
          p = close_word();
          push_score(p, 1'b0);
        end
      end
      default: begin
        p = 8'sd0;
        if (word_len > 0 || too_long) p = close_word();
        push_score(p, 1'b1);
        total    = 0;
        count    = 0;
        word_len = 0;
        too_long = 0;
      end
    endcase
  endfunction

  function void check_score(logic signed [7:0] pol, logic signed [15:0] tot,
                            logic [7:0] cnt, logic last);
    score_t s;
    n_scores++;
    if (pending_scores.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: pol %0d total %0d count %0d end %0d",
                 pol, tot, cnt, last);
      return;
    end
    s = pending_scores.pop_front();
    if (pol !== s.pol || tot !== s.total || cnt !== s.count || last !== s.last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch on result %0d: expected pol %0d total %0d count %0d end %0d, got pol %0d total %0d count %0d end %0d",
                 n_scores, s.pol, s.total, s.count, s.last, pol, tot, cnt, last);
    end
  endfunction
endclass

module testbench;
  import lwps_pkg::*;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [6:0]         cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         mode;
  logic [5:0]         entry_index;
  logic [4:0]         char_position;
  logic [7:0]         char_code;
  logic signed [7:0]  polarity_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [7:0]  word_polarity;
  logic signed [15:0] total_polarity;
  logic [7:0]         word_count;
  logic               comment_end;

  score_tracker      sb;
  logic [7:0]        lex_text [DEF_LEX_DEPTH][DEF_MAX_WORD];
  int                lex_len [DEF_LEX_DEPTH];
  logic signed [7:0] lex_pol_host [DEF_LEX_DEPTH];
  int                cur_size = 0;
  int                burst_left = 0;
  int                n_sent = 0;
  int                sizes_used = 0;
  int                stall_style = 0;
  int                style_left = 0;

  lexicon_word_polarity_scorer_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .entry_index    (entry_index),
    .char_position  (char_position),
    .char_code      (char_code),
    .polarity_value (polarity_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .word_polarity  (word_polarity),
    .total_polarity (total_polarity),
    .word_count     (word_count),
    .comment_end    (comment_end)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 3);
      style_left  = $urandom_range(100, 600);
    end
    style_left--;
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 4) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((style_left % 9) < 4);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_score(word_polarity, total_polarity, word_count, comment_end);
  end

  // one input transaction, with burst and gap pacing
  task automatic send_item(mode_t m, logic [5:0] e, logic [4:0] pos, logic [7:0] ch,
                           logic signed [7:0] pol);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0:       gap = $urandom_range(8, 30);
        1, 2, 3: gap = $urandom_range(1, 4);
        default: gap = 0;
      endcase
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid       = 1'b1;
    mode           = m;
    entry_index    = e;
    char_position  = pos;
    char_code      = ch;
    polarity_value = pol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.score_transaction(m, e, pos, ch, pol);
    n_sent++;
  endtask

  task automatic send_byte(logic [7:0] ch);
    send_item(MODE_BYTE, 6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)), ch,
              8'($urandom_range(0, 255)));
  endtask

  task automatic send_end();
    send_item(MODE_END, 6'($urandom_range(0, 63)), 5'($urandom_range(0, 31)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do
      b = 8'($urandom_range(0, 255));
    while (((b | CASE_BIT) >= CHAR_LO_A && (b | CASE_BIT) <= CHAR_LO_Z) ||
           b == CHAR_SPACE);
    return b;
  endfunction

  task automatic say_letter(logic [7:0] c);
    if ($urandom_range(0, 15) == 0) send_byte(junk_byte());
    send_byte(c);
  endtask

  task automatic say_entry(int e);
    logic [7:0] c;
    for (int k = 0; k < lex_len[e]; k++) begin
      c = lex_text[e][k];
      if (c >= CHAR_LO_A && c <= CHAR_LO_Z && $urandom_range(0, 3) == 0) c = c ^ CASE_BIT;
      say_letter(c);
    end
  endtask

  function automatic void make_word(int e, int len);
    lex_len[e] = len;
    for (int k = 0; k < len; k++)
      lex_text[e][k] = 8'($urandom_range(CHAR_LO_A, CHAR_LO_Z));
  endfunction

  // writes the whole entry, with its terminator when shorter than DEF_MAX_WORD, then its polarity
  task automatic load_entry(int e);
    for (int k = 0; k < lex_len[e]; k++)
      send_item(MODE_LEX_CHAR, 6'(e), 5'(k), lex_text[e][k], 8'($urandom_range(0, 255)));
    if (lex_len[e] < DEF_MAX_WORD)
      send_item(MODE_LEX_CHAR, 6'(e), 5'(lex_len[e]), CHAR_NUL, 8'($urandom_range(0, 255)));
    send_item(MODE_LEX_POL, 6'(e), 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
              lex_pol_host[e]);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(logic [6:0] v);
    drain();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sb.set_size(v);
    cur_size = v;
    sizes_used++;
  endtask

  task automatic random_comment();
    int words;
    int kind;
    int len;
    int eff;
    int e;
    logic [7:0] c;
    eff   = (cur_size > DEF_LEX_DEPTH) ? DEF_LEX_DEPTH : cur_size;
    words = $urandom_range(0, 10);
    for (int w = 0; w < words; w++) begin
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        if (eff > 0 && $urandom_range(0, 9) < 7) e = $urandom_range(0, eff - 1);
        else e = $urandom_range(0, DEF_LEX_DEPTH - 1);
        say_entry(e);
      end else if (kind < 18) begin
        len = (kind < 16) ? $urandom_range(1, 8) : $urandom_range(19, 23);
        for (int k = 0; k < len; k++) begin
          c = 8'($urandom_range(CHAR_LO_A, CHAR_LO_Z));
          if ($urandom_range(0, 1) == 1) c = c ^ CASE_BIT;
          say_letter(c);
        end
      end
      if (w < words - 1 || $urandom_range(0, 1) == 1) send_byte(CHAR_SPACE);
    end
    send_end();
  endtask

  // long run of one-letter words saturating count, and total if the polarity is extreme
  task automatic saturating_comment(int e);
    repeat (262) begin
      say_entry(e);
      send_byte(CHAR_SPACE);
    end
    send_end();
  endtask

  initial begin
    int phase;
    int bulk;
    int mark;
    int e;
    int p;
    logic [6:0] sz;

    sb             = new();
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    mode           = MODE_LEX_CHAR;
    entry_index    = '0;
    char_position  = '0;
    char_code      = '0;
    polarity_value = '0;
    out_stall      = 1'b0;

    for (int i = 0; i < DEF_LEX_DEPTH; i++) begin
      make_word(i, $urandom_range(1, 8));
      lex_pol_host[i] = 8'($urandom_range(0, 255));
    end
    make_word(0, 1);
    lex_text[0][0] = "a";
    lex_pol_host[0] = 8'h7f;
    make_word(1, 1);
    lex_text[1][0] = "b";
    lex_pol_host[1] = 8'h80;
    lex_len[2] = 0;
    make_word(3, DEF_MAX_WORD);
    make_word(4, DEF_MAX_WORD - 1);
    lex_len[5] = 4;
    lex_text[5][0] = "G";
    lex_text[5][1] = "o";
    lex_text[5][2] = "o";
    lex_text[5][3] = "d";
    lex_len[6] = 3;
    lex_text[6][0] = "x";
    lex_text[6][1] = 8'he9;
    lex_text[6][2] = "y";
    make_word(8, 2);
    lex_text[8][0] = "a";
    lex_text[8][1] = "b";
    make_word(9, 3);
    lex_text[9][0] = "a";
    lex_text[9][1] = "b";
    lex_text[9][2] = "c";
    // later duplicate of entry 7, first match must win
    lex_len[30] = lex_len[7];
    for (int k = 0; k < DEF_MAX_WORD; k++) lex_text[30][k] = lex_text[7][k];

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_size(7'd64);
    for (int i = 0; i < DEF_LEX_DEPTH; i++) load_entry(i);

    // directed corner cases
    send_byte(CHAR_SPACE);
    send_byte("A");
    send_byte(CHAR_SPACE);
    send_byte(8'h80);
    send_byte(8'hff);
    send_byte("1");
    send_byte("B");
    send_end();
    send_end();
    send_item(MODE_LEX_CHAR, 6'd63, 5'd31, 8'hff, 8'h00);
    send_item(MODE_LEX_POL, 6'd63, 5'd0, 8'h00, 8'h80);
    send_item(MODE_LEX_POL, 6'd62, 5'd31, 8'hff, 8'h7f);

    phase = 0;
    bulk  = 0;
    while (bulk < 1550) begin
      case (phase)
        0:       sz = 7'd0;
        1:       sz = 7'd127;
        2:       sz = 7'd1;
        3:       sz = 7'd64;
        4:       sz = 7'd65;
        5:       sz = 7'd11;
        default: sz = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(64, 127))
                                                  : 7'($urandom_range(0, 63));
      endcase
      write_size(sz);
      if (phase == 1) saturating_comment(0);
      if (phase == 3) saturating_comment(1);
      repeat ($urandom_range(3, 10)) begin
        mark = n_sent;
        if ($urandom_range(0, 5) == 0)
          send_item(MODE_LEX_CHAR, 6'($urandom_range(0, 63)), 5'($urandom_range(20, 31)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0) begin
          e = $urandom_range(0, 63);
          lex_pol_host[e] = 8'($urandom_range(0, 255));
          send_item(MODE_LEX_POL, 6'(e), 5'($urandom_range(0, 31)),
                    8'($urandom_range(0, 255)), lex_pol_host[e]);
        end
        if ($urandom_range(0, 11) == 0) begin
          e = $urandom_range(11, 63);
          make_word(e, ($urandom_range(0, 5) == 0) ? DEF_MAX_WORD : $urandom_range(1, 8));
          lex_pol_host[e] = 8'($urandom_range(0, 255));
          load_entry(e);
        end
        if ($urandom_range(0, 9) == 0) begin
          e = $urandom_range(11, 63);
          p = $urandom_range(0, lex_len[e] - 1);
          lex_text[e][p] = 8'($urandom_range(CHAR_LO_A, CHAR_LO_Z));
          send_item(MODE_LEX_CHAR, 6'(e), 5'(p), lex_text[e][p], 8'($urandom_range(0, 255)));
        end
        random_comment();
        bulk += n_sent - mark;
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d transactions sent, %0d results checked, %0d lexicon size settings",
             n_sent, sb.n_scores, sizes_used);
    $display("covered empty, dropped, too-long and saturating words plus lexicon rewrites");
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
